// ===== rtl/pixel_gamma_scale_clamp_macros.svh =====
// Assertion macros shared by the pixel gain and clamp RTL.
// Depends on nothing; the asserting module must have clk and arst_n in scope.
`ifndef PIXEL_GAMMA_SCALE_CLAMP_MACROS_SVH
`define PIXEL_GAMMA_SCALE_CLAMP_MACROS_SVH

`ifndef SYNTH

// expr must never be true outside reset
`define PGSC_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("pgsc assertion failed");

// when ante holds, cons must hold in the next cycle
`define PGSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pgsc assertion failed");

`else

`define PGSC_ASSERT_NEVER(lbl, expr)
`define PGSC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/pgsc_pkg.sv =====
// Shared types, constants and register indexes for the pixel gain and clamp block.
// Used by pgsc_front, pgsc_fifo, pgsc_back and pixel_gamma_scale_clamp.
`timescale 1ns / 1ps
`default_nettype none

package pgsc_pkg;

	localparam int BYTE_W      = 8;
	localparam int GAIN_W      = 16;
	localparam int BPP_W       = 8;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int PROD_W      = BYTE_W + GAIN_W;
	localparam int REM_W       = 2 * BYTE_W;
	localparam int DIV_STEPS   = BYTE_W;
	localparam int PIX_DATA_W  = 4 * BYTE_W;

	localparam int PGSC_FIFO_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BPP  = CFG_IDX_W'(1);

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
	localparam logic [BPP_W-1:0]  BPP_RESET  = BPP_W'(32);
	localparam logic [BPP_W-1:0]  BPP_24     = BPP_W'(24);
	localparam logic [BPP_W-1:0]  BPP_32     = BPP_W'(32);

	// 255.0 in 16.8 fixed point: scaled channels above this get clamped
	localparam logic [PROD_W-1:0] BYTE_MAX_Q8 = PROD_W'(255 * 256);

	typedef enum logic [1:0] {
		MODE_BYPASS,
		MODE_PLAIN,
		MODE_CLAMP
	} mode_t;

	// One classified pixel between front and back.
	// For bypass and plain pixels the bytes are final; for clamp pixels
	// they are the raw colour bytes and dmax is the largest of them.
	typedef struct packed {
		mode_t             mode;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] dmax;
		logic [BYTE_W-1:0] alpha;
		logic              last;
	} qentry_t;

	// One stage of the back-end divider pipeline
	typedef struct packed {
		mode_t             mode;
		logic [REM_W-1:0]  rem_r;
		logic [REM_W-1:0]  rem_g;
		logic [REM_W-1:0]  rem_b;
		logic [BYTE_W-1:0] q_r;
		logic [BYTE_W-1:0] q_g;
		logic [BYTE_W-1:0] q_b;
		logic [BYTE_W-1:0] dmax;
		logic [BYTE_W-1:0] alpha;
		logic              last;
	} div_stage_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

// ===== rtl/pgsc_front.sv =====
// Front end: configuration registers, pixel intake and classification.
// Depends on pgsc_pkg; feeds pgsc_fifo.
`timescale 1ns / 1ps
`default_nettype none

module pgsc_front
	import pgsc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PIX_DATA_W-1:0] in_data,
	input  wire logic                  in_last,
	input  wire qstat_t                qstat,
	output logic                       push,
	output qentry_t                    push_data
);

	logic [GAIN_W-1:0] gain_q;
	logic [BPP_W-1:0]  bpp_q;

	logic              vld_s1;
	logic [BYTE_W-1:0] red_s1, green_s1, blue_s1, alpha_s1, cmax_s1;
	logic              last_s1, bypass_s1;

	logic              vld_s2;
	qentry_t           ent_s2;

	logic              adv;
	logic [BYTE_W-1:0] red_in, green_in, blue_in, alpha_in, max_rg;
	logic [PROD_W-1:0] prod_r, prod_g, prod_b, prod_m;
	qentry_t           ent_nxt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			bpp_q  <= BPP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GAIN: gain_q <= cfg_data;
				REG_BPP:  bpp_q  <= cfg_data[BPP_W-1:0];
				default:  ;
			endcase
		end
	end

	// whole front advances together; it only stalls on a full queue
	assign adv      = !vld_s2 || !qstat.full;
	assign in_ready = adv;
	assign push     = vld_s2 && !qstat.full;
	assign push_data = ent_s2;

	assign red_in   = in_data[BYTE_W-1:0];
	assign green_in = in_data[2*BYTE_W-1:BYTE_W];
	assign blue_in  = in_data[3*BYTE_W-1:2*BYTE_W];
	assign alpha_in = in_data[4*BYTE_W-1:3*BYTE_W];
	assign max_rg   = (green_in > red_in) ? green_in : red_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s1    <= red_in;
			green_s1  <= green_in;
			blue_s1   <= blue_in;
			alpha_s1  <= alpha_in;
			last_s1   <= in_last;
			cmax_s1   <= (blue_in > max_rg) ? blue_in : max_rg;
			bypass_s1 <= !(bpp_q inside {BPP_24, BPP_32});
			ent_s2    <= ent_nxt;
		end
	end

	// scaled max compares like the max of the scaled channels
	assign prod_r = PROD_W'(red_s1) * PROD_W'(gain_q);
	assign prod_g = PROD_W'(green_s1) * PROD_W'(gain_q);
	assign prod_b = PROD_W'(blue_s1) * PROD_W'(gain_q);
	assign prod_m = PROD_W'(cmax_s1) * PROD_W'(gain_q);

	always_comb begin
		ent_nxt.dmax  = cmax_s1;
		ent_nxt.alpha = alpha_s1;
		ent_nxt.last  = last_s1;
		if (bypass_s1) begin
			ent_nxt.mode  = MODE_BYPASS;
			ent_nxt.red   = red_s1;
			ent_nxt.green = green_s1;
			ent_nxt.blue  = blue_s1;
		end else if (prod_m > BYTE_MAX_Q8) begin
			ent_nxt.mode  = MODE_CLAMP;
			ent_nxt.red   = red_s1;
			ent_nxt.green = green_s1;
			ent_nxt.blue  = blue_s1;
		end else begin
			ent_nxt.mode  = MODE_PLAIN;
			ent_nxt.red   = prod_r[2*BYTE_W-1:BYTE_W];
			ent_nxt.green = prod_g[2*BYTE_W-1:BYTE_W];
			ent_nxt.blue  = prod_b[2*BYTE_W-1:BYTE_W];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pgsc_fifo.sv =====
// Short queue of classified pixels between front and back end.
// Depends on pgsc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "pixel_gamma_scale_clamp_macros.svh"

module pgsc_fifo
	import pgsc_pkg::*;
#(
	parameter int DEPTH = PGSC_FIFO_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire qentry_t push_data,
	input  wire logic    pop,
	output qentry_t      pop_data,
	output qstat_t       qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qentry_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign qstat.full  = (cnt_q == CNT_W'(DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	`PGSC_ASSERT_NEVER(a_no_push_full, push && qstat.full)
	`PGSC_ASSERT_NEVER(a_no_pop_empty, pop && qstat.empty)
	`PGSC_ASSERT_NEXT(a_push_fills, push && !pop, !qstat.empty)

endmodule

`default_nettype wire

// ===== rtl/pgsc_back.sv =====
// Back end: pipelined restoring divider for clamped pixels and output register.
// Depends on pgsc_pkg; pops classified pixels from pgsc_fifo.
`timescale 1ns / 1ps
`default_nettype none

module pgsc_back
	import pgsc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire qstat_t                qstat,
	input  wire qentry_t               pop_data,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [PIX_DATA_W-1:0]      out_data,
	output logic                       out_last
);

	div_stage_t st_s [DIV_STEPS+1];
	logic       vld_s [DIV_STEPS+1];
	div_stage_t nxt [DIV_STEPS+1];
	logic       adv;

	function automatic void div_bit(
		input  logic [REM_W-1:0]  rem_in,
		input  logic [REM_W-1:0]  trial,
		output logic [REM_W-1:0]  rem_out,
		output logic              qbit
	);
		qbit    = (rem_in >= trial);
		rem_out = qbit ? (rem_in - trial) : rem_in;
	endfunction

	// the last stage is the output register; stall everything while it is held
	assign adv       = !vld_s[DIV_STEPS] || out_ready;
	assign pop       = adv && !qstat.empty;
	assign out_valid = vld_s[DIV_STEPS];
	assign out_data  = {st_s[DIV_STEPS].alpha, st_s[DIV_STEPS].q_b,
		st_s[DIV_STEPS].q_g, st_s[DIV_STEPS].q_r};
	assign out_last  = st_s[DIV_STEPS].last;

	always_comb begin
		logic [REM_W-1:0] trial;
		logic             qb;
		logic [REM_W-1:0] rem;

		// load: dividend is c * 255, quotient starts empty for clamp pixels
		nxt[0].mode  = pop_data.mode;
		nxt[0].dmax  = pop_data.dmax;
		nxt[0].alpha = pop_data.alpha;
		nxt[0].last  = pop_data.last;
		nxt[0].rem_r = {pop_data.red, BYTE_W'(0)} - REM_W'(pop_data.red);
		nxt[0].rem_g = {pop_data.green, BYTE_W'(0)} - REM_W'(pop_data.green);
		nxt[0].rem_b = {pop_data.blue, BYTE_W'(0)} - REM_W'(pop_data.blue);
		if (pop_data.mode == MODE_CLAMP) begin
			nxt[0].q_r = '0;
			nxt[0].q_g = '0;
			nxt[0].q_b = '0;
		end else begin
			nxt[0].q_r = pop_data.red;
			nxt[0].q_g = pop_data.green;
			nxt[0].q_b = pop_data.blue;
		end

		// one quotient bit per stage, most significant first
		for (int i = 1; i <= DIV_STEPS; i++) begin
			nxt[i] = st_s[i-1];
			trial  = REM_W'(st_s[i-1].dmax) << (DIV_STEPS - i);
			rem    = '0;
			qb     = 1'b0;
			if (st_s[i-1].mode == MODE_CLAMP) begin
				div_bit(st_s[i-1].rem_r, trial, rem, qb);
				nxt[i].rem_r = rem;
				nxt[i].q_r[DIV_STEPS-i] = qb;
				div_bit(st_s[i-1].rem_g, trial, rem, qb);
				nxt[i].rem_g = rem;
				nxt[i].q_g[DIV_STEPS-i] = qb;
				div_bit(st_s[i-1].rem_b, trial, rem, qb);
				nxt[i].rem_b = rem;
				nxt[i].q_b[DIV_STEPS-i] = qb;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_STEPS; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= pop;
			for (int i = 1; i <= DIV_STEPS; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i <= DIV_STEPS; i++) begin
				st_s[i] <= nxt[i];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pixel_gamma_scale_clamp.sv =====
// RGB gain with hue-preserving clamp. Takes one pixel per clock on the input
// stream and gives one result per clock on the output stream once the pipe is
// full, as long as the output is not stalled. The rate is set by the fully
// pipelined 8-stage restoring divider in the back end, which retires one
// quotient bit of all three channels per stage, and by the front end's single
// stage of four 8x16 gain multipliers. The queue between the two lets the
// intake keep taking pixels while the output is stalled, until it fills. The user
// is to write configuration (gain, pixel size) only while idle; nothing checks it.
`timescale 1ns / 1ps
`default_nettype none

module pixel_gamma_scale_clamp
	import pgsc_pkg::*;
#(
	parameter int FIFO_DEPTH = PGSC_FIFO_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// red_in [7:0], green_in [15:8], blue_in [23:16], alpha_in [31:24]
	input  wire logic [PIX_DATA_W-1:0] s_axis_tdata,
	input  wire logic                  s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// red_out [7:0], green_out [15:8], blue_out [23:16], alpha_out [31:24]
	output logic [PIX_DATA_W-1:0]      m_axis_tdata,
	output logic                       m_axis_tlast
);

	qstat_t  qstat;
	logic    push, pop;
	qentry_t push_data, pop_data;

	pgsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	pgsc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	pgsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire
